FILE: rtl/core/apo_pkg.sv
// ----------------------------------------------------------------------------
// apo_pkg
// Shared types and constants of the audio peak overview block.
// ----------------------------------------------------------------------------
package apo_pkg;

  localparam int LEVEL_W = 20;
  localparam int DIV_A_W = 36;
  localparam int DIV_B_W = 20;
  localparam int ADDR_W  = 4;

  localparam logic [LEVEL_W-1:0] Q16_ONE   = 20'h10000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 20'hFFFFF;

  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_FRAMES   = 2'd2;
  localparam logic [1:0] REG_BINS     = 2'd3;

  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_F32 = 2'd2;

  localparam logic [1:0] ST_NORM   = 2'd0;
  localparam logic [1:0] ST_RAW    = 2'd1;
  localparam logic [1:0] ST_NODATA = 2'd2;

  typedef struct packed {
    logic [1:0]  sample_format;
    logic [3:0]  channel_count;
    logic [31:0] total_frames;
    logic [6:0]  bin_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sample_word;
    logic        last_sample;
  } sample_t;

  typedef struct packed {
    logic [19:0] peak_level;
    logic [5:0]  bin_number;
    logic [1:0]  status;
    logic        last_bin;
  } result_t;

endpackage

FILE: rtl/core/audio_peak_overview.sv
// ----------------------------------------------------------------------------
// audio_peak_overview
// Waveform peak decimation of an interleaved PCM sample stream.
// ----------------------------------------------------------------------------
// Usage: samples enter one per request on the sample channel (valid/ready),
// channels interleaved; last_sample marks the final sample of a clip. The
// APB port sets format, channel count, total frames and bin count; write it
// only while the block is idle.
// A sample that closes a counted frame goes through the channel mean in
// the serial divider and the bin setup, then a peak store read and a
// write back for each bin it touches. After the last sample, each bin
// takes a store read, plus the divider when normalizing, then leaves
// through the result register; a run ends with last_bin set. A run
// without any counted frame gives one no-data result.
// The result register frees the core as soon as a request is taken; when
// the receiver stalls, the core holds its next result and takes no sample.
// Reset clears the run and the registers; the peak store needs no clearing.
// ----------------------------------------------------------------------------
module audio_peak_overview
  import apo_pkg::*;
#(
  parameter int MAX_BINS     = 64,
  parameter int MAX_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sample_t           sample,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    res_valid;
  logic    res_ready;
  result_t res_item;

  apo_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apo_ctrl #(
    .MAX_BINS     (MAX_BINS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample_valid),
    .in_ready  (sample_ready),
    .in_item   (sample),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // take a new result whenever the output register is empty or draining
  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) result <= res_item;
  end

endmodule

FILE: rtl/core/apo_cfg.sv
// ----------------------------------------------------------------------------
// apo_cfg
// APB register file: sample format, channel count, total frames, bin count.
// ----------------------------------------------------------------------------
module apo_cfg
  import apo_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_format <= FMT_S16;
      cfg.channel_count <= 4'd2;
      cfg.total_frames  <= 32'd1;
      cfg.bin_count     <= 7'd64;
    end else if (wr) begin
      unique case (idx)
        REG_FORMAT:   cfg.sample_format <= pwdata[1:0];
        REG_CHANNELS: cfg.channel_count <= pwdata[3:0];
        REG_FRAMES:   cfg.total_frames  <= pwdata;
        REG_BINS:     cfg.bin_count     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FORMAT:   prdata = {30'd0, cfg.sample_format};
      REG_CHANNELS: prdata = {28'd0, cfg.channel_count};
      REG_FRAMES:   prdata = cfg.total_frames;
      REG_BINS:     prdata = {25'd0, cfg.bin_count};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/core/apo_div.sv
// ----------------------------------------------------------------------------
// apo_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apo_div
  import apo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_A_W-1:0] dvd,
  input  logic [DIV_B_W-1:0] dvs,
  output logic               done,
  output logic [DIV_A_W-1:0] quo
);

  localparam int CW = $clog2(DIV_A_W + 1);

  logic [DIV_B_W:0]   rem;
  logic [DIV_B_W-1:0] dvs_q;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic [DIV_B_W:0]   shifted;
  logic               take;

  assign shifted = {rem[DIV_B_W-1:0], quo[DIV_A_W-1]};
  assign take    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_A_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dvd;
      dvs_q <= dvs;
    end else if (busy) begin
      rem <= take ? (shifted - {1'b0, dvs_q}) : shifted;
      quo <= {quo[DIV_A_W-2:0], take};
    end
  end

endmodule

FILE: rtl/core/apo_ctrl.sv
// ----------------------------------------------------------------------------
// apo_ctrl
// Frame mixing, per-bin peak store with read-modify-write, and emission.
// ----------------------------------------------------------------------------
module apo_ctrl
  import apo_pkg::*;
#(
  parameter int MAX_BINS     = 64,
  parameter int MAX_CHANNELS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_item
);

  localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
  localparam int CH_IW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W  = LEVEL_W + $clog2(MAX_CHANNELS);
  localparam int PW     = CNT_W + 33;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIV   = 10'b0000000010,
    S_PREP1 = 10'b0000000100,
    S_PREP2 = 10'b0000001000,
    S_CHK   = 10'b0000010000,
    S_UPD   = 10'b0000100000,
    S_ERD   = 10'b0001000000,
    S_EGET  = 10'b0010000000,
    S_EDIV  = 10'b0100000000,
    S_EOUT  = 10'b1000000000
  } state_t;

  state_t state;

  logic [LEVEL_W-1:0] peak_mem [MAX_BINS];
  logic [LEVEL_W-1:0] rdata;

  logic [SUM_W-1:0]   chan_sum;
  logic [CH_IW-1:0]   chan_idx;
  logic [31:0]        frame_idx;
  logic [CNT_W-1:0]   cur_bin;
  logic [CNT_W-1:0]   fill;
  logic [LEVEL_W-1:0] ovr_max;
  logic [LEVEL_W-1:0] level;
  logic               last_pend;
  logic [CNT_W-1:0]   bin_i;
  logic [PW-1:0]      bnd;
  logic [PW-1:0]      m1;
  logic [PW-1:0]      m2;
  logic               n_le;
  logic [LEVEL_W-1:0] res_peak;
  logic [1:0]         res_st;

  logic [CNT_W-1:0]   r_eff;
  logic [CH_W-1:0]    ch_eff;
  logic [LEVEL_W-1:0] mag;
  logic [SUM_W-1:0]   sum_new;
  logic               accept;
  logic               frame_end;
  logic               counted;
  logic [32:0]        f1;
  logic [PW-1:0]      m1_prod;
  logic [PW-1:0]      bnd_prod;
  logic [PW-1:0]      bnd_step;
  logic [LEVEL_W-1:0] old_peak;
  logic               div_start;
  logic [DIV_A_W-1:0] div_a;
  logic [DIV_B_W-1:0] div_b;
  logic               div_done;
  logic [DIV_A_W-1:0] div_q;
  logic               mem_re;
  logic               mem_we;
  logic               res_last;

  function automatic logic [LEVEL_W-1:0] sample_mag(input logic [1:0] fmt,
                                                    input logic [31:0] w);
    logic [7:0]         b8;
    logic [7:0]         d8;
    logic [15:0]        v16;
    logic [7:0]         ex;
    logic [23:0]        sig;
    logic [4:0]         sh;
    logic [LEVEL_W-1:0] m;
    b8  = w[7:0];
    d8  = (b8 >= 8'd128) ? (b8 - 8'd128) : (8'd128 - b8);
    v16 = w[15] ? (16'd0 - w[15:0]) : w[15:0];
    ex  = w[30:23];
    sig = {1'b1, w[22:0]};
    sh  = 5'(8'd134 - ex);
    case (fmt)
      FMT_U8:  m = {3'd0, d8, 9'd0};
      FMT_F32: begin
        if (ex == 8'hFF)       m = (w[22:0] != 23'd0) ? '0 : LEVEL_MAX;
        else if (ex == 8'd0)   m = '0;
        else if (ex >= 8'd131) m = LEVEL_MAX;
        else if (ex < 8'd110)  m = '0;
        else                   m = LEVEL_W'(sig >> sh);
      end
      default: m = {3'd0, v16, 1'b0};
    endcase
    return m;
  endfunction

  always_comb begin
    if (cfg.bin_count == 7'd0)            r_eff = CNT_W'(1);
    else if (cfg.bin_count > MAX_BINS)    r_eff = CNT_W'(MAX_BINS);
    else                                  r_eff = CNT_W'(cfg.bin_count);
    if (cfg.channel_count == 4'd0)        ch_eff = CH_W'(1);
    else if (cfg.channel_count > MAX_CHANNELS) ch_eff = CH_W'(MAX_CHANNELS);
    else                                  ch_eff = CH_W'(cfg.channel_count);
  end

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mag       = sample_mag(cfg.sample_format, in_item.sample_word);
  assign sum_new   = chan_sum + SUM_W'(mag);
  assign frame_end = ((CH_W + 1)'(chan_idx) + 1'b1) >= (CH_W + 1)'(ch_eff);
  assign counted   = frame_idx < cfg.total_frames;
  assign f1        = {1'b0, frame_idx} + 33'd1;
  assign m1_prod   = f1 * r_eff;
  assign bnd_prod  = cur_bin * cfg.total_frames;
  assign bnd_step  = bnd + PW'(cfg.total_frames);
  assign old_peak  = (bin_i < fill) ? rdata : '0;

  always_comb begin
    if (state == S_IDLE) begin
      div_start = accept && frame_end && counted;
      div_a     = DIV_A_W'(sum_new);
      div_b     = DIV_B_W'(ch_eff);
    end else begin
      div_start = (state == S_EGET) && (ovr_max != '0);
      div_a     = {old_peak, 16'd0};
      div_b     = ovr_max;
    end
  end

  apo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dvd   (div_a),
    .dvs   (div_b),
    .done  (div_done),
    .quo   (div_q)
  );

  // bins are touched in order, so only the check state and the emission read
  assign mem_re = ((state == S_CHK) && (bin_i < r_eff) && (bnd < m1)) || (state == S_ERD);
  // write the first touch of a bin even at zero so the entry becomes defined
  assign mem_we = (state == S_UPD) && ((level > old_peak) || (bin_i >= fill));

  always_ff @(posedge clk) begin
    if (mem_re) rdata <= peak_mem[bin_i[BIN_AW-1:0]];
    if (mem_we) peak_mem[bin_i[BIN_AW-1:0]] <= level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chan_sum  <= '0;
      chan_idx  <= '0;
      frame_idx <= '0;
      cur_bin   <= '0;
      fill      <= '0;
      ovr_max   <= '0;
      last_pend <= 1'b0;
      bin_i     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_pend <= in_item.last_sample;
            if (frame_end) begin
              chan_sum <= '0;
              chan_idx <= '0;
            end else begin
              chan_sum <= sum_new;
              chan_idx <= chan_idx + 1'b1;
            end
            bin_i <= '0;
            if (frame_end && counted) begin
              state <= S_DIV;
            end else if (in_item.last_sample) begin
              if (frame_idx == 32'd0) begin
                res_peak <= '0;
                res_st   <= ST_NODATA;
                state    <= S_EOUT;
              end else begin
                state <= S_ERD;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            level <= div_q[LEVEL_W-1:0];
            state <= S_PREP1;
          end
        end
        S_PREP1: begin
          m1    <= m1_prod;
          bnd   <= bnd_prod;
          n_le  <= {1'b0, cfg.total_frames} <= f1;
          bin_i <= cur_bin;
          if (level > ovr_max) ovr_max <= level;
          state <= S_PREP2;
        end
        S_PREP2: begin
          m2    <= m1 + PW'(r_eff);
          state <= S_CHK;
        end
        S_CHK: begin
          if (mem_re) begin
            state <= S_UPD;
          end else begin
            frame_idx <= frame_idx + 32'd1;
            bin_i     <= '0;
            state     <= last_pend ? S_ERD : S_IDLE;
          end
        end
        S_UPD: begin
          // close the bin once its end reaches the next frame
          if (bnd_step < m2 || n_le) cur_bin <= bin_i + 1'b1;
          if (bin_i >= fill) fill <= bin_i + 1'b1;
          bin_i <= bin_i + 1'b1;
          bnd   <= bnd_step;
          state <= S_CHK;
        end
        S_ERD: state <= S_EGET;
        S_EGET: begin
          if (ovr_max != '0) begin
            state <= S_EDIV;
          end else begin
            res_peak <= old_peak;
            res_st   <= ST_RAW;
            state    <= S_EOUT;
          end
        end
        S_EDIV: begin
          if (div_done) begin
            res_peak <= (div_q > DIV_A_W'(Q16_ONE)) ? Q16_ONE : div_q[LEVEL_W-1:0];
            res_st   <= ST_NORM;
            state    <= S_EOUT;
          end
        end
        S_EOUT: begin
          if (res_ready) begin
            if (res_last) begin
              chan_sum  <= '0;
              chan_idx  <= '0;
              frame_idx <= '0;
              cur_bin   <= '0;
              fill      <= '0;
              ovr_max   <= '0;
              state     <= S_IDLE;
            end else begin
              bin_i <= bin_i + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_valid = (state == S_EOUT);
  assign res_last  = (res_st == ST_NODATA) || (CNT_W'(bin_i + 1'b1) == r_eff);

  always_comb begin
    res_item.peak_level = res_peak;
    res_item.bin_number = 6'(bin_i);
    res_item.status     = res_st;
    res_item.last_bin   = res_last;
  end

  ap_cur_fill: assert property (@(posedge clk) disable iff (rst) cur_bin <= fill)
    else $error("closed bins run past written bins");

  ap_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV || state == S_EDIV))
    else $error("divider finished outside a wait state");

  ap_norm_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_st == ST_NORM) |-> res_peak <= Q16_ONE)
    else $error("normalized peak above one");

  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EOUT && !res_ready) |=> (state == S_EOUT))
    else $error("result dropped while stalled");

endmodule
